@@ design/bdqs_pkg.sv @@
package bdqs_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic [IDX_W-1:0]             t_idx;
    typedef logic [CNT_W-1:0]             t_cnt;

    // request codes
    typedef enum logic [2:0] {
        F_PUSH_FRONT = 3'd0,
        F_PUSH_BACK  = 3'd1,
        F_POP_FRONT  = 3'd2,
        F_POP_BACK   = 3'd3,
        F_FIND       = 3'd4,
        F_DELETE     = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_NOTFOUND = 2'd3
    } t_status;

    // what every cell does on the update cycle
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_FRONT,
        CELL_PUSH_BACK,
        CELL_POP_FRONT,
        CELL_DELETE
    } t_cell_op;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic     cmp_en;
        t_cell_op op;
        t_data    key;
    } t_cell_ctl;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] operand;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] popped_value;
        logic [3:0]         position;
        logic [4:0]         occupancy;
    } t_out_beat;

    // operand -> stored width (sign-extend, then cut)
    function automatic t_data to_stored(logic signed [31:0] v);
        return DATA_WIDTH'(v);
    endfunction

    // stored value -> 32-bit result field
    function automatic logic signed [31:0] to_out32(t_data d);
        return 32'(d);
    endfunction

endpackage

@@ design/bdqs_cell.sv @@
module bdqs_cell
    import bdqs_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_live,
    input  logic      i_tail,
    input  t_data     i_left,
    input  t_data     i_right,
    input  logic      i_hit_in,
    output t_data     o_data,
    output logic      o_match,
    output logic      o_hit_out
);

    t_data r_data;
    t_data n_data;
    logic  r_match;
    logic  n_match;

    always_comb begin
        n_match = r_match;
        if (i_ctl.cmp_en) begin
            n_match = i_live && (r_data == i_ctl.key);
        end
    end

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            CELL_PUSH_FRONT: n_data = i_left;
            CELL_PUSH_BACK: begin
                if (i_tail) begin
                    n_data = i_ctl.key;
                end
            end
            CELL_POP_FRONT: n_data = i_right;
            CELL_DELETE: begin
                // first match and every cell behind it move one toward the front
                if (i_hit_in || r_match) begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_match <= n_match;
    end

    assign o_data    = r_data;
    assign o_match   = r_match;
    assign o_hit_out = i_hit_in || r_match;

endmodule

@@ design/bdqs_ctrl.sv @@
module bdqs_ctrl
    import bdqs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_beat         i_in_beat,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_beat        o_out_beat,
    input  t_data            i_cell_data [DEPTH],
    input  logic [DEPTH-1:0] i_first_hit,
    input  logic             i_found,
    output t_cell_ctl        o_cell_ctl,
    output logic [DEPTH-1:0] o_live,
    output logic [DEPTH-1:0] o_tail
);

    t_state     r_state;
    t_state     n_state;
    logic [2:0] r_func;
    t_data      r_key;
    t_cnt       r_count;
    t_cnt       n_count;
    logic       r_out_valid;
    t_out_beat  r_out_beat;
    t_out_beat  n_out_beat;

    logic       accept;
    logic       done;
    logic       full;
    logic       empty;
    t_cnt       last_cnt;
    t_idx       last_idx;
    t_idx       hit_pos;
    t_cell_op   op;

    assign accept   = (r_state == S_IDLE) && i_in_valid;
    assign done     = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign full     = (r_count == t_cnt'(DEPTH));
    assign empty    = (r_count == '0);
    assign last_cnt = r_count - t_cnt'(1);
    assign last_idx = last_cnt[IDX_W-1:0];

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            o_live[i] = t_cnt'(i) < r_count;
            o_tail[i] = t_cnt'(i) == r_count;
        end
    end

    always_comb begin
        hit_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            hit_pos = hit_pos | (i_first_hit[i] ? t_idx'(i) : t_idx'(0));
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath decisions
    always_comb begin
        op                      = CELL_HOLD;
        n_count                 = r_count;
        n_out_beat.status       = STAT_OK;
        n_out_beat.popped_value = '0;
        n_out_beat.position     = '0;
        case (r_func)
            F_PUSH_FRONT, F_PUSH_BACK: begin
                if (full) begin
                    n_out_beat.status = STAT_FULL;
                end else begin
                    op      = (r_func == F_PUSH_FRONT) ? CELL_PUSH_FRONT : CELL_PUSH_BACK;
                    n_count = r_count + t_cnt'(1);
                end
            end
            F_POP_FRONT: begin
                if (empty) begin
                    n_out_beat.status = STAT_EMPTY;
                end else begin
                    op                      = CELL_POP_FRONT;
                    n_count                 = last_cnt;
                    n_out_beat.popped_value = to_out32(i_cell_data[0]);
                end
            end
            F_POP_BACK: begin
                if (empty) begin
                    n_out_beat.status = STAT_EMPTY;
                end else begin
                    n_count                 = last_cnt;
                    n_out_beat.popped_value = to_out32(i_cell_data[last_idx]);
                end
            end
            F_FIND: begin
                if (empty) begin
                    n_out_beat.status = STAT_EMPTY;
                end else if (!i_found) begin
                    n_out_beat.status = STAT_NOTFOUND;
                end else begin
                    n_out_beat.position = 4'(hit_pos);
                end
            end
            F_DELETE: begin
                if (empty) begin
                    n_out_beat.status = STAT_EMPTY;
                end else if (!i_found) begin
                    n_out_beat.status = STAT_NOTFOUND;
                end else begin
                    op      = CELL_DELETE;
                    n_count = last_cnt;
                end
            end
            default: op = CELL_HOLD;
        endcase
        n_out_beat.occupancy = 5'(n_count);

        o_cell_ctl.cmp_en = accept;
        o_cell_ctl.op     = done ? op : CELL_HOLD;
        o_cell_ctl.key    = (r_state == S_IDLE) ? to_stored(i_in_beat.operand) : r_key;
        o_in_stall        = (r_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (done) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_in_beat.func;
            r_key  <= to_stored(i_in_beat.operand);
        end
        if (done) begin
            r_out_beat <= n_out_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

@@ design/bounded_deque_with_search_core.sv @@
// The edge that accepts a request moves the control to S_EXEC; leaving S_EXEC loads its result
// beat into the output register, later while an earlier result still waits there.
// A request is taken only in S_IDLE, so one is finished before the next; when a beat is taken every cell registers
// its compare, and in S_EXEC the first hit resolves along the cell chain and the cells shift or load.
// A new request is taken while the previous result still waits in the output register.
// Reset (i_rst_n low, synchronous): list empty, no result pending, ready for a request.
// Cell contents are not reset; only cells below the fill count are ever read.
module bounded_deque_with_search_core
    import bdqs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    // one cell per list slot, slot 0 is the front
    t_cell_ctl        cell_ctl;
    t_data            cell_data [DEPTH];
    logic [DEPTH-1:0] cell_match;
    logic [DEPTH-1:0] hit_chain;   // any match at or in front of this cell
    logic [DEPTH-1:0] first_hit;
    logic [DEPTH-1:0] live;
    logic [DEPTH-1:0] tail;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_data left_data;
            t_data right_data;
            logic  hit_in;

            // front cell takes the key on push front
            if (g == 0) begin : g_front
                assign left_data = cell_ctl.key;
                assign hit_in    = 1'b0;
            end else begin : g_mid
                assign left_data = cell_data[g-1];
                assign hit_in    = hit_chain[g-1];
            end

            // back cell just keeps its value on a left shift
            if (g == DEPTH - 1) begin : g_back
                assign right_data = cell_data[g];
            end else begin : g_inner
                assign right_data = cell_data[g+1];
            end

            bdqs_cell u_cell (
                .i_clk     (i_clk),
                .i_ctl     (cell_ctl),
                .i_live    (live[g]),
                .i_tail    (tail[g]),
                .i_left    (left_data),
                .i_right   (right_data),
                .i_hit_in  (hit_in),
                .o_data    (cell_data[g]),
                .o_match   (cell_match[g]),
                .o_hit_out (hit_chain[g])
            );

            assign first_hit[g] = cell_match[g] && !hit_in;
        end
    endgenerate

    // sequencing, fill count and result register
    bdqs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat),
        .i_cell_data (cell_data),
        .i_first_hit (first_hit),
        .i_found     (hit_chain[DEPTH-1]),
        .o_cell_ctl  (cell_ctl),
        .o_live      (live),
        .o_tail      (tail)
    );

endmodule

@@ design/bdqs_checker.sv @@
module bdqs_checker
    import bdqs_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_beat  i_in_beat,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_beat
);

    // one request in flight: after a beat is taken the input side stalls
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepted beat");

    a_popped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.status != STAT_OK) |-> (o_out_beat.popped_value == '0))
        else $error("popped value set on failed request");

    a_position_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.position != '0) |-> (o_out_beat.status == STAT_OK))
        else $error("position set on failed request");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.status == STAT_EMPTY) |-> (o_out_beat.occupancy == '0))
        else $error("empty status with nonzero occupancy");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.status == STAT_FULL) |-> (o_out_beat.occupancy == 5'(DEPTH)))
        else $error("full status with occupancy below depth");

endmodule

bind bounded_deque_with_search_core bdqs_checker u_bdqs_checker (.*);
